/* rtl/core/image_moments_by_projections_assert.svh */
// Assertion macros for the moment engine checkers.
`ifndef IMAGE_MOMENTS_BY_PROJECTIONS_ASSERT_SVH
`define IMAGE_MOMENTS_BY_PROJECTIONS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IMBP_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define IMBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/imbp_pkg.sv */
`default_nettype none
package imbp_pkg;

  localparam int unsigned CFG_BITS     = 11;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_BITS-1:0]     CFG_DIM_RESET    = 11'd1024;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DEF_PIXEL_BITS = 8;
  localparam int unsigned PIX_PORT_BITS  = 8;

  localparam int unsigned ACC_BITS = 56;
  localparam int unsigned NUM_MOM  = 10;
  localparam int unsigned NUM_TERM = 5;

  // Output field widths.
  localparam int unsigned W_M00 = 28;
  localparam int unsigned W_M1  = 37;
  localparam int unsigned W_M2  = 47;
  localparam int unsigned W_M11 = 46;
  localparam int unsigned W_M3  = 56;

  // Multiply steps; step s feeds moment accumulator s+1.
  localparam int unsigned STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] STEP_PX   = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_PY   = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_PX2  = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_PXY  = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_PY2  = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_PX3  = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_PX2Y = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_PXY2 = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_PY3  = 4'd8;

  typedef logic [NUM_MOM-1:0][ACC_BITS-1:0] acc_arr_t;

  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    logic [STEP_BITS-1:0] mul_sel;
    logic                 clear;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/imbp_ctrl.sv */
`default_nettype none
module imbp_ctrl import imbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy,
  output logic    valid_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = STEP_PX;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_q;
        if (cnt_q == STEP_PY3) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        state_d = status_i.frame_end ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_DONE);

endmodule
`default_nettype wire

/* rtl/core/imbp_datapath.sv */
`default_nettype none
module imbp_datapath import imbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [PIX_PORT_BITS-1:0] pixel_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i,
  output acc_arr_t                acc_o
);

  localparam int unsigned XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned DW = (XW > YW) ? XW : YW;
  localparam int unsigned AW = PIXEL_BITS + 2 * DW;
  localparam int unsigned PW = AW + DW;
  localparam int unsigned DMW = (($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                                 $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1));
  localparam int unsigned DB  = (DMW > CFG_BITS) ? DMW : CFG_BITS;

  logic [CFG_BITS-1:0]   width_q, height_q;
  logic [DB-1:0]         eff_w, eff_h;
  logic [XW-1:0]         col_q;
  logic [YW-1:0]         row_q;
  logic                  last_col, last_row, frame_end_q;
  logic [PIXEL_BITS-1:0] p_q, p_in;
  logic [15:0]           pix_ext;
  logic [DW-1:0]         x_q, y_q, b_mux;
  logic [AW-1:0]         a_mux;
  logic [AW-1:0]         term_q [NUM_TERM];
  logic [PW-1:0]         prod_q;
  logic                  acc_en_q;
  logic [STEP_BITS-1:0]  sel_q, acc_idx;
  acc_arr_t              acc_q;
  logic                  cfg_hit, wipe;

  assign pix_ext = 16'(pixel_i);
  assign p_in    = pix_ext[PIXEL_BITS-1:0];

  // A zero dimension acts as one, an oversized one as the maximum.
  always_comb begin
    if (width_q == '0)                          eff_w = DB'(1);
    else if (DB'(width_q) > DB'(MAX_WIDTH))     eff_w = DB'(MAX_WIDTH);
    else                                        eff_w = DB'(width_q);
    if (height_q == '0)                         eff_h = DB'(1);
    else if (DB'(height_q) > DB'(MAX_HEIGHT))   eff_h = DB'(MAX_HEIGHT);
    else                                        eff_h = DB'(height_q);
  end

  assign last_col = (DB'(col_q) + DB'(1)) >= eff_w;
  assign last_row = (DB'(row_q) + DB'(1)) >= eff_h;

  assign cfg_hit = cfg_we_i &&
                   ((cfg_idx_i == REG_IMAGE_WIDTH) || (cfg_idx_i == REG_IMAGE_HEIGHT));
  assign wipe    = cfg_hit || cmd_i.clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_RESET;
      height_q <= CFG_DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_IMAGE_WIDTH)  width_q  <= cfg_wdata_i;
      if (cfg_idx_i == REG_IMAGE_HEIGHT) height_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      frame_end_q <= 1'b0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load) begin
      frame_end_q <= last_col & last_row;
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + YW'(1);
      end else begin
        col_q <= col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q <= p_in;
      x_q <= DW'(col_q);
      y_q <= DW'(row_q);
    end
  end

  always_comb begin
    a_mux = '0;
    b_mux = y_q;
    case (cmd_i.mul_sel)
      STEP_PX:   begin a_mux = AW'(p_q);   b_mux = x_q; end
      STEP_PY:   a_mux = AW'(p_q);
      STEP_PX2:  begin a_mux = term_q[0];  b_mux = x_q; end
      STEP_PXY:  a_mux = term_q[0];
      STEP_PY2:  a_mux = term_q[1];
      STEP_PX3:  begin a_mux = term_q[2];  b_mux = x_q; end
      STEP_PX2Y: a_mux = term_q[2];
      STEP_PXY2: a_mux = term_q[3];
      STEP_PY3:  a_mux = term_q[4];
      default:   a_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= PW'(a_mux) * PW'(b_mux);
    sel_q <= cmd_i.mul_sel;
    if (acc_en_q && (sel_q < STEP_BITS'(NUM_TERM))) begin
      term_q[sel_q[2:0]] <= AW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_en_q <= 1'b0;
    else         acc_en_q <= cmd_i.mul_en;
  end

  assign acc_idx = sel_q + STEP_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (wipe) begin
      acc_q <= '0;
    end else begin
      if (cmd_i.load) acc_q[0] <= acc_q[0] + ACC_BITS'(p_in);
      if (acc_en_q)   acc_q[acc_idx] <= acc_q[acc_idx] + ACC_BITS'(prod_q);
    end
  end

  assign status_o.frame_end = frame_end_q;
  assign acc_o              = acc_q;

endmodule
`default_nettype wire

/* rtl/core/image_moments_by_projections.sv */
`default_nettype none
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------
// pixel in  | start & !busy             | pixel_i
// config    | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
// moments   | valid_o, one-cycle strobe | m00_o .. m03_o
//
// Each pixel word is loaded, then makes nine passes through the
// single shared multiplier (p*x, p*y, then raising to second and third
// order), and a drain state then folds the last product into its sum.
// After the last pixel of a frame, valid_o presents the ten moments in
// a one-cycle strobe; the sums clear at the end of that cycle.
// Reset (rst_ni low, async) clears positions and sums and sets both
// dimensions to 1024. The receiver cannot stall; busy is the only back
// pressure on the pixel side.
module image_moments_by_projections import imbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // pixel word
  input  logic                     start,
  output logic                     busy,
  input  logic [PIX_PORT_BITS-1:0] pixel_i,
  // register writes
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_BITS-1:0]      cfg_wdata_i,
  // moment word
  output logic                     valid_o,
  output logic [W_M00-1:0]         m00_o,
  output logic [W_M1-1:0]          m10_o,
  output logic [W_M1-1:0]          m01_o,
  output logic [W_M2-1:0]          m20_o,
  output logic [W_M11-1:0]         m11_o,
  output logic [W_M2-1:0]          m02_o,
  output logic [W_M3-1:0]          m30_o,
  output logic [W_M3-1:0]          m21_o,
  output logic [W_M3-1:0]          m12_o,
  output logic [W_M3-1:0]          m03_o
);

  cmd_t     cmd;
  status_t  status;
  acc_arr_t acc;

  imbp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .valid_o  (valid_o)
  );

  imbp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pixel_i     (pixel_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_o       (acc)
  );

  // Sums are kept modulo 2^56; each moment is the low bits of its sum.
  assign m00_o = acc[0][W_M00-1:0];
  assign m10_o = acc[1][W_M1-1:0];
  assign m01_o = acc[2][W_M1-1:0];
  assign m20_o = acc[3][W_M2-1:0];
  assign m11_o = acc[4][W_M11-1:0];
  assign m02_o = acc[5][W_M2-1:0];
  assign m30_o = acc[6][W_M3-1:0];
  assign m21_o = acc[7][W_M3-1:0];
  assign m12_o = acc[8][W_M3-1:0];
  assign m03_o = acc[9][W_M3-1:0];

endmodule
`default_nettype wire

/* rtl/core/imbp_checker.sv */
`default_nettype none
`include "image_moments_by_projections_assert.svh"
module imbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o
);

  // accepted pixel keeps the engine occupied next cycle
  `IMBP_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // a moment word only comes out of a working engine
  `IMBP_ASSERT(a_valid_busy, clk_i, rst_ni, valid_o, busy)
  // one strobe per frame, then idle
  `IMBP_ASSERT_NEXT(a_valid_single, clk_i, rst_ni, valid_o, !valid_o && !busy)
  // no word right after an acceptance
  `IMBP_ASSERT_NEXT(a_no_early, clk_i, rst_ni, start && !busy, !valid_o)

endmodule

bind image_moments_by_projections imbp_checker u_imbp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);
`default_nettype wire

/* test/image_moments_by_projections_tb.sv */
`default_nettype none
// Frame moment engine testbench.
// Pixel words go in raster order on a start/busy handshake. A frame sum model
// in the bench accumulates p, p*x, p*y ... p*y^3 straight from the pixel
// coordinates, and one expected moment word is queued per completed frame.
// Moment words are strobed on valid_o and checked against the oldest entry.
module image_moments_by_projections_tb;
  import imbp_pkg::*;

  // Index codes the block does not decode; writes to them must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN_CYCLES = 24;  // longer than one pixel word plus the strobe

  typedef struct {
    logic [W_M00-1:0] m00;
    logic [W_M1-1:0]  m10;
    logic [W_M1-1:0]  m01;
    logic [W_M2-1:0]  m20;
    logic [W_M11-1:0] m11;
    logic [W_M2-1:0]  m02;
    logic [W_M3-1:0]  m30;
    logic [W_M3-1:0]  m21;
    logic [W_M3-1:0]  m12;
    logic [W_M3-1:0]  m03;
  } moments_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [PIX_PORT_BITS-1:0] pixel_i;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_BITS-1:0]      cfg_wdata_i;
  logic                     valid_o;
  logic [W_M00-1:0]         m00_o;
  logic [W_M1-1:0]          m10_o;
  logic [W_M1-1:0]          m01_o;
  logic [W_M2-1:0]          m20_o;
  logic [W_M11-1:0]         m11_o;
  logic [W_M2-1:0]          m02_o;
  logic [W_M3-1:0]          m30_o;
  logic [W_M3-1:0]          m21_o;
  logic [W_M3-1:0]          m12_o;
  logic [W_M3-1:0]          m03_o;

  image_moments_by_projections i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o    (valid_o),
    .m00_o      (m00_o),
    .m10_o      (m10_o),
    .m01_o      (m01_o),
    .m20_o      (m20_o),
    .m11_o      (m11_o),
    .m02_o      (m02_o),
    .m30_o      (m30_o),
    .m21_o      (m21_o),
    .m12_o      (m12_o),
    .m03_o      (m03_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Frame sum model: register shadows, raster position and running sums.
  logic [CFG_BITS-1:0] width_reg, height_reg;
  int unsigned         col_pos, row_pos;
  bit [63:0]           sum_p, sum_x, sum_y, sum_xx, sum_xy, sum_yy;
  bit [63:0]           sum_xxx, sum_xxy, sum_xyy, sum_yyy;
  moments_t            frame_moments_q[$];

  int unsigned pixels_sent;
  int unsigned frames_done;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned burst_left;

  function automatic int unsigned active_dim(logic [CFG_BITS-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void clear_frame_sums();
    col_pos = 0;
    row_pos = 0;
    {sum_p, sum_x, sum_y, sum_xx, sum_xy, sum_yy} = '0;
    {sum_xxx, sum_xxy, sum_xyy, sum_yyy} = '0;
  endfunction

  // Fold one accepted pixel in; queue a moment word when the frame closes.
  function automatic void accumulate_pixel(logic [PIX_PORT_BITS-1:0] pix);
    bit [63:0] p, x, y;
    moments_t  m;
    p = 64'(pix);
    x = 64'(col_pos);
    y = 64'(row_pos);
    sum_p   += p;
    sum_x   += p * x;
    sum_y   += p * y;
    sum_xx  += p * x * x;
    sum_xy  += p * x * y;
    sum_yy  += p * y * y;
    sum_xxx += p * x * x * x;
    sum_xxy += p * x * x * y;
    sum_xyy += p * x * y * y;
    sum_yyy += p * y * y * y;
    if (col_pos + 1 >= active_dim(width_reg, DEF_MAX_WIDTH)) begin
      col_pos = 0;
      if (row_pos + 1 >= active_dim(height_reg, DEF_MAX_HEIGHT)) begin
        m.m00 = sum_p[W_M00-1:0];
        m.m10 = sum_x[W_M1-1:0];
        m.m01 = sum_y[W_M1-1:0];
        m.m20 = sum_xx[W_M2-1:0];
        m.m11 = sum_xy[W_M11-1:0];
        m.m02 = sum_yy[W_M2-1:0];
        m.m30 = sum_xxx[W_M3-1:0];
        m.m21 = sum_xxy[W_M3-1:0];
        m.m12 = sum_xyy[W_M3-1:0];
        m.m03 = sum_yyy[W_M3-1:0];
        frame_moments_q.push_back(m);
        frames_done++;
        clear_frame_sums();
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d actual %0d", what, want, got);
  endfunction

  // Moment word checker; the receiver side never stalls.
  always @(posedge clk_i) begin
    moments_t m;
    if (rst_ni && valid_o) begin
      if (frame_moments_q.size() == 0) begin
        note_mismatch("unexpected moment word, m00", 64'd0, 64'(m00_o));
      end else begin
        m = frame_moments_q.pop_front();
        if (m00_o !== m.m00) note_mismatch("m00", 64'(m.m00), 64'(m00_o));
        if (m10_o !== m.m10) note_mismatch("m10", 64'(m.m10), 64'(m10_o));
        if (m01_o !== m.m01) note_mismatch("m01", 64'(m.m01), 64'(m01_o));
        if (m20_o !== m.m20) note_mismatch("m20", 64'(m.m20), 64'(m20_o));
        if (m11_o !== m.m11) note_mismatch("m11", 64'(m.m11), 64'(m11_o));
        if (m02_o !== m.m02) note_mismatch("m02", 64'(m.m02), 64'(m02_o));
        if (m30_o !== m.m30) note_mismatch("m30", 64'(m.m30), 64'(m30_o));
        if (m21_o !== m.m21) note_mismatch("m21", 64'(m.m21), 64'(m21_o));
        if (m12_o !== m.m12) note_mismatch("m12", 64'(m.m12), 64'(m12_o));
        if (m03_o !== m.m03) note_mismatch("m03", 64'(m.m03), 64'(m03_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("image_moments_by_projections_tb failed");
      $finish;
    end
  end

  // Send one pixel word. Bursts of random length with random gaps between;
  // start drops for one cycle after each accepted word, while the engine
  // is still busy with it.
  task automatic send_pixel(logic [PIX_PORT_BITS-1:0] pix);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : $urandom_range(0, 2))
        @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    start   <= 1'b1;
    pixel_i <= pix;
    do @(posedge clk_i); while (busy);
    accumulate_pixel(pix);
    pixels_sent++;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Block is idle once every moment word is back and the pixel pipe drained.
  task automatic wait_idle();
    while (frame_moments_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val;
      clear_frame_sums();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val;
      clear_frame_sums();
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame_random(int unsigned n);
    repeat (n) send_pixel(PIX_PORT_BITS'($urandom_range(0, 255)));
  endtask

  function automatic int unsigned frame_len();
    return active_dim(width_reg, DEF_MAX_WIDTH) * active_dim(height_reg, DEF_MAX_HEIGHT);
  endfunction

  // Tiny frames, pixel extremes.
  task automatic test_small_frames();
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    send_pixel(8'd255);
    send_pixel(8'd0);
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    repeat (4) send_pixel(8'd255);
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    send_pixel(8'h55);
    send_pixel(8'haa);
    send_pixel(8'h0f);
    send_pixel(8'hf0);
    send_pixel(8'h01);
    send_pixel(8'h80);
  endtask

  // Register write mid-frame restarts it; spare indexes leave it alone.
  task automatic test_frame_restart();
    write_reg(REG_IMAGE_WIDTH, 11'd4);
    write_reg(REG_IMAGE_HEIGHT, 11'd4);
    send_frame_random(5);
    write_reg(REG_IMAGE_WIDTH, 11'd4);
    send_frame_random(16);
    send_frame_random(3);
    write_reg(REG_SPARE_2, 11'h7ff);
    write_reg(REG_SPARE_3, 11'h5aa);
    send_frame_random(13);
  endtask

  // Full-size rows and columns; zero and oversize dimensions saturate.
  task automatic test_dimension_extremes();
    write_reg(REG_IMAGE_WIDTH, 11'd2047);
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    repeat (1024) send_pixel(8'd255);
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd2047);
    repeat (1024) send_pixel(8'd255);
    write_reg(REG_IMAGE_WIDTH, 11'd1025);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    send_frame_random(4);
  endtask

  // Mostly complete small frames, some cut short by a register write.
  task automatic test_random_frames();
    int unsigned target;
    int unsigned frames_goal;
    target      = pixels_sent + 100;
    frames_goal = frames_done + 8;
    while (pixels_sent < target || frames_done < frames_goal) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: write_reg(REG_SPARE_2, CFG_BITS'($urandom_range(0, 2047)));
          1: write_reg(REG_SPARE_3, CFG_BITS'($urandom_range(0, 2047)));
          default: ;
        endcase
        write_reg(REG_IMAGE_WIDTH,
                  CFG_BITS'($urandom_range(0, 9) == 0 ? $urandom_range(0, 12)
                                                      : $urandom_range(1, 6)));
        write_reg(REG_IMAGE_HEIGHT,
                  CFG_BITS'($urandom_range(0, 9) == 0 ? $urandom_range(0, 12)
                                                      : $urandom_range(1, 6)));
      end
      if (frame_len() > 1 && $urandom_range(0, 7) == 0) begin
        send_frame_random($urandom_range(1, frame_len() - 1));
        write_reg(REG_IMAGE_WIDTH, width_reg);
      end else begin
        send_frame_random(frame_len() * $urandom_range(1, 2));
      end
      // pause the sender until all moment words are back, now and then
      if ($urandom_range(0, 9) == 0)
        while (frame_moments_q.size() != 0) @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    pixel_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_IMAGE_WIDTH;
    cfg_wdata_i = '0;
    width_reg   = CFG_DIM_RESET;
    height_reg  = CFG_DIM_RESET;
    pixels_sent = 0;
    frames_done = 0;
    mismatches  = 0;
    cycle_cnt   = 0;
    burst_left  = 0;
    clear_frame_sums();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_small_frames();
    test_frame_restart();
    test_dimension_extremes();
    test_random_frames();

    while (frame_moments_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("image_moments_by_projections_tb passed");
    end else begin
      $display("image_moments_by_projections_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
